### design/i2crd_pkg.sv
// Shared types and constants of the register-read bus master.
package i2crd_pkg;

    // Field widths fixed by the word formats.
    localparam int HALF_W = 16;
    localparam int BYTE_W = 8;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Default width of the phase hold counter.
    localparam int HOLD_BITS_DEFAULT = 16;

    // Reset value of the half period register.
    localparam logic [HALF_W-1:0] HALF_RESET = 16'd250;

    // Register index of the half period register (paddr bit 2).
    localparam logic REG_HALF_PERIOD = 1'b0;

    // Read/write bit of an address byte.
    localparam logic [BYTE_W-1:0] READ_BIT = 8'h01;

    // One input word.
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_index;
        logic              scl_line;
        logic              sda_line;
    } t_item;

    // One result word.
    typedef struct packed {
        logic              scl_release;
        logic              sda_release;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_write_addr;
        logic              ack_register;
        logic              ack_read_addr;
    } t_result;

endpackage

### design/i2crd_ifs.sv
// Valid/ready channel interfaces for the input and result words.
interface i2crd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] dev_addr;
    logic [7:0] reg_index;
    logic       scl_line;
    logic       sda_line;

    modport source (output valid, kind, dev_addr, reg_index, scl_line, sda_line,
                    input ready);
    modport sink (input valid, kind, dev_addr, reg_index, scl_line, sda_line,
                  output ready);
endinterface

interface i2crd_out_if;
    logic       valid;
    logic       ready;
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_write_addr;
    logic       ack_register;
    logic       ack_read_addr;

    modport source (output valid, scl_release, sda_release, busy_res, done_res,
                    read_data, ack_write_addr, ack_register, ack_read_addr,
                    input ready);
    modport sink (input valid, scl_release, sda_release, busy_res, done_res,
                  read_data, ack_write_addr, ack_register, ack_read_addr,
                  output ready);
endinterface

### design/i2crd_seq.sv
// Bus phase sequencer: advances the transfer by one tick per accepted word.
module i2crd_seq import i2crd_pkg::*; #(
    parameter int HOLD_COUNTER_BITS = HOLD_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_item             i_item,
    input  logic [HALF_W-1:0] i_half,
    output t_result           o_result
);

    localparam int HB = HOLD_COUNTER_BITS;
    localparam int CW = (HB > HALF_W) ? HB : HALF_W;
    localparam logic [CW-1:0] HOLD_CAP = CW'((64'd1 << HB) - 64'd1);

    // Line drive bits: bit 0 releases the clock, bit 1 the data line.
    localparam logic [1:0] LN_NONE = 2'b00;
    localparam logic [1:0] LN_SCL  = 2'b01;
    localparam logic [1:0] LN_SDA  = 2'b10;
    localparam logic [1:0] LN_BOTH = 2'b11;

    typedef enum logic [27:0] {
        PH_IDLE    = 28'h0000001,
        PH_S1A     = 28'h0000002,
        PH_S1B     = 28'h0000004,
        PH_S1C     = 28'h0000008,
        PH_S1D     = 28'h0000010,
        PH_TXA_LO  = 28'h0000020,
        PH_TXA_HI  = 28'h0000040,
        PH_ACKA_LO = 28'h0000080,
        PH_ACKA_HI = 28'h0000100,
        PH_TXR_LO  = 28'h0000200,
        PH_TXR_HI  = 28'h0000400,
        PH_ACKR_LO = 28'h0000800,
        PH_ACKR_HI = 28'h0001000,
        PH_S2A     = 28'h0002000,
        PH_S2B     = 28'h0004000,
        PH_S2C     = 28'h0008000,
        PH_S2D     = 28'h0010000,
        PH_TXD_LO  = 28'h0020000,
        PH_TXD_HI  = 28'h0040000,
        PH_ACKD_LO = 28'h0080000,
        PH_ACKD_HI = 28'h0100000,
        PH_RX_LO   = 28'h0200000,
        PH_RX_HI   = 28'h0400000,
        PH_NACK_LO = 28'h0800000,
        PH_NACK_HI = 28'h1000000,
        PH_SP_A    = 28'h2000000,
        PH_SP_B    = 28'h4000000,
        PH_SP_C    = 28'h8000000
    } t_phase;

    // Line levels on entry to a phase; some phases only change one line.
    function automatic logic [1:0] enter_line(input t_phase p, input logic [1:0] line,
                                              input logic [BYTE_W-1:0] sh);
        logic [1:0] res;
        res = LN_BOTH;
        case (p)
            PH_S1A:                                 res = LN_BOTH;
            PH_S1B, PH_S2B:                         res = line | LN_SCL;
            PH_S1C, PH_S2C:                         res = line & ~LN_SDA;
            PH_S1D, PH_S2D:                         res = line & ~LN_SCL;
            PH_S2A:                                 res = LN_SDA;
            PH_TXA_LO, PH_TXR_LO, PH_TXD_LO:        res = sh[BYTE_W-1] ? LN_SDA : LN_NONE;
            PH_TXA_HI, PH_TXR_HI, PH_TXD_HI:        res = line | LN_SCL;
            PH_ACKA_LO, PH_ACKR_LO, PH_ACKD_LO:     res = LN_SDA;
            PH_ACKA_HI, PH_ACKR_HI, PH_ACKD_HI:     res = line | LN_SCL;
            PH_RX_LO, PH_NACK_LO:                   res = LN_SDA;
            PH_RX_HI, PH_NACK_HI, PH_SP_C:          res = LN_BOTH;
            PH_SP_A:                                res = LN_NONE;
            PH_SP_B:                                res = LN_SCL;
            default:                                res = LN_BOTH;
        endcase
        return res;
    endfunction

    t_phase            r_phase, n_phase;
    logic [3:0]        r_bit_count, n_bit_count;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [HB-1:0]     r_hold, n_hold;
    logic [BYTE_W-1:0] r_addr, n_addr;
    logic [BYTE_W-1:0] r_reg, n_reg;
    logic [BYTE_W-1:0] r_recv, n_recv;
    logic [2:0]        r_ack, n_ack;
    logic [1:0]        r_line, n_line;

    logic [CW-1:0] half_ext;
    logic [CW-1:0] lim_sat;
    logic [HB-1:0] hold_lim;
    logic [HB-1:0] hold_inc;
    logic [3:0]    bc_inc;
    logic          fin;
    logic          go;
    logic          done;
    t_phase        tgt;

    // Hold limit: saturate to the counter range, and treat zero as one.
    always_comb begin
        half_ext = CW'(i_half);
        lim_sat  = (half_ext > HOLD_CAP) ? HOLD_CAP : half_ext;
        hold_lim = (lim_sat == '0) ? HB'(1) : lim_sat[HB-1:0];
    end

    assign hold_inc = r_hold + HB'(1);
    assign bc_inc   = r_bit_count + 4'd1;

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_hold      = r_hold;
        n_addr      = r_addr;
        n_reg       = r_reg;
        n_recv      = r_recv;
        n_ack       = r_ack;
        n_line      = r_line;
        fin         = 1'b0;
        go          = 1'b0;
        done        = 1'b0;
        tgt         = PH_IDLE;

        case (r_phase)
            PH_IDLE: begin
                if (i_item.kind) begin
                    n_addr      = i_item.dev_addr;
                    n_reg       = i_item.reg_index;
                    n_ack       = 3'b111;
                    n_bit_count = 4'd0;
                    go          = 1'b1;
                    tgt         = PH_S1A;
                end
            end
            PH_RX_HI: begin
                // The device may hold the clock low; restart the count then.
                if (!i_item.scl_line) begin
                    n_hold = '0;
                end else begin
                    n_hold = hold_inc;
                    fin    = (hold_inc >= hold_lim);
                end
            end
            PH_S1A, PH_S1B, PH_S1C, PH_S1D, PH_TXA_LO, PH_TXA_HI, PH_ACKA_LO,
            PH_ACKA_HI, PH_TXR_LO, PH_TXR_HI, PH_ACKR_LO, PH_ACKR_HI, PH_S2A,
            PH_S2B, PH_S2C, PH_S2D, PH_TXD_LO, PH_TXD_HI, PH_ACKD_LO, PH_ACKD_HI,
            PH_RX_LO, PH_NACK_LO, PH_NACK_HI, PH_SP_A, PH_SP_B, PH_SP_C: begin
                if (r_hold >= hold_lim) begin
                    fin = 1'b1;
                end else begin
                    n_hold = hold_inc;
                end
            end
            default: begin
                go  = 1'b1;
                tgt = PH_IDLE;
            end
        endcase

        if (fin) begin
            go = 1'b1;
            case (r_phase)
                PH_S1A:     tgt = PH_S1B;
                PH_S1B:     tgt = PH_S1C;
                PH_S1C:     tgt = PH_S1D;
                PH_S2A:     tgt = PH_S2B;
                PH_S2B:     tgt = PH_S2C;
                PH_S2C:     tgt = PH_S2D;
                PH_TXA_LO:  tgt = PH_TXA_HI;
                PH_TXR_LO:  tgt = PH_TXR_HI;
                PH_TXD_LO:  tgt = PH_TXD_HI;
                PH_ACKA_LO: tgt = PH_ACKA_HI;
                PH_ACKR_LO: tgt = PH_ACKR_HI;
                PH_ACKD_LO: tgt = PH_ACKD_HI;
                PH_RX_LO:   tgt = PH_RX_HI;
                PH_NACK_LO: tgt = PH_NACK_HI;
                PH_NACK_HI: tgt = PH_SP_A;
                PH_SP_A:    tgt = PH_SP_B;
                PH_SP_B:    tgt = PH_SP_C;
                PH_S1D: begin
                    n_shift     = r_addr;
                    n_bit_count = 4'd0;
                    tgt         = PH_TXA_LO;
                end
                PH_S2D: begin
                    n_shift     = r_addr | READ_BIT;
                    n_bit_count = 4'd0;
                    tgt         = PH_TXD_LO;
                end
                PH_TXA_HI: begin
                    n_shift     = {r_shift[BYTE_W-2:0], 1'b0};
                    n_bit_count = bc_inc;
                    tgt         = (bc_inc >= 4'd8) ? PH_ACKA_LO : PH_TXA_LO;
                end
                PH_TXR_HI: begin
                    n_shift     = {r_shift[BYTE_W-2:0], 1'b0};
                    n_bit_count = bc_inc;
                    tgt         = (bc_inc >= 4'd8) ? PH_ACKR_LO : PH_TXR_LO;
                end
                PH_TXD_HI: begin
                    n_shift     = {r_shift[BYTE_W-2:0], 1'b0};
                    n_bit_count = bc_inc;
                    tgt         = (bc_inc >= 4'd8) ? PH_ACKD_LO : PH_TXD_LO;
                end
                PH_ACKA_HI: begin
                    n_ack[0]    = i_item.sda_line;
                    n_shift     = r_reg;
                    n_bit_count = 4'd0;
                    tgt         = PH_TXR_LO;
                end
                PH_ACKR_HI: begin
                    n_ack[1] = i_item.sda_line;
                    tgt      = PH_S2A;
                end
                PH_ACKD_HI: begin
                    n_ack[2]    = i_item.sda_line;
                    n_shift     = '0;
                    n_bit_count = 4'd0;
                    tgt         = PH_RX_LO;
                end
                PH_RX_HI: begin
                    n_shift     = {r_shift[BYTE_W-2:0], i_item.sda_line};
                    n_bit_count = bc_inc;
                    if (bc_inc >= 4'd8) begin
                        n_recv = n_shift;
                        tgt    = PH_NACK_LO;
                    end else begin
                        tgt = PH_RX_LO;
                    end
                end
                PH_SP_C: begin
                    done = 1'b1;
                    tgt  = PH_IDLE;
                end
                default: tgt = PH_IDLE;
            endcase
        end

        if (go) begin
            n_phase = tgt;
            n_hold  = ((tgt == PH_RX_HI) || (tgt == PH_IDLE)) ? '0 : HB'(1);
            n_line  = enter_line(tgt, r_line, n_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_hold      <= '0;
            r_addr      <= '0;
            r_reg       <= '0;
            r_recv      <= '0;
            r_ack       <= 3'b111;
            r_line      <= LN_BOTH;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_hold      <= n_hold;
            r_addr      <= n_addr;
            r_reg       <= n_reg;
            r_recv      <= n_recv;
            r_ack       <= n_ack;
            r_line      <= n_line;
        end
    end

    always_comb begin
        o_result.scl_release    = n_line[0];
        o_result.sda_release    = n_line[1];
        o_result.busy_res       = (n_phase != PH_IDLE);
        o_result.done_res       = done;
        o_result.read_data      = n_recv;
        o_result.ack_write_addr = n_ack[0];
        o_result.ack_register   = n_ack[1];
        o_result.ack_read_addr  = n_ack[2];
    end

endmodule

### design/i2c_register_read_master_core.sv
// Top level of the register-read bus master: sequencer, output buffer and APB register.
//
// This block runs one register read on an open-drain two-wire bus: start, device
// write address, register number, repeated start, device read address, one byte
// received MSB first with a NACK from the master, and stop. Every accepted input
// word is one timing tick, and a start word (kind = 1) begins a read only while
// the block is idle. Each accepted word produces exactly one result word that
// carries the line drive, busy and done flags, the received byte and the three
// acknowledge bits. The sequencer updates all of its state together, so the block
// accepts one word every clock cycle while the skid register is free; each result
// is registered into the output register or the skid register. A two-entry
// output buffer (an output register plus a skid register) sits between the sides,
// so input is still taken while one result waits; input stalls only once both
// entries are full. Each line phase lasts half_period_ticks ticks (APB byte
// address 0, reset 250); the clock-high phase of a received bit restarts its count
// on every tick at which the device holds the clock low.
module i2c_register_read_master_core import i2crd_pkg::*; #(
    parameter int HOLD_COUNTER_BITS = HOLD_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2crd_in_if.sink          i_in,
    i2crd_out_if.source       o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [HALF_W-1:0] r_half_period;
    logic              r_out_valid;
    logic              r_skid_valid;
    t_result           r_out_data;
    t_result           r_skid_data;
    t_item             item;
    t_result           result;
    logic              step;
    logic              cfg_wr;

    // Configuration register. Writes always complete in the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_RESET;
        end else if (cfg_wr && (paddr[2] == REG_HALF_PERIOD)) begin
            r_half_period <= pwdata[HALF_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_HALF_PERIOD) ? APB_DW'(r_half_period) : '0;

    // Input side. A word is taken whenever the skid register is free.
    assign i_in.ready = !r_skid_valid;
    assign step       = i_in.valid && !r_skid_valid;

    always_comb begin
        item.kind      = i_in.kind;
        item.dev_addr  = i_in.dev_addr;
        item.reg_index = i_in.reg_index;
        item.scl_line  = i_in.scl_line;
        item.sda_line  = i_in.sda_line;
    end

    i2crd_seq #(
        .HOLD_COUNTER_BITS(HOLD_COUNTER_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (item),
        .i_half  (r_half_period),
        .o_result(result)
    );

    // Output buffer. The output register refills from the skid register first,
    // so result words leave in the order they were made.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= step;
            end else begin
                r_out_valid <= step;
            end
        end else if (step) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_skid_data <= result;
        end
        if (!r_out_valid || o_out.ready) begin
            r_out_data <= r_skid_valid ? r_skid_data : result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.scl_release    = r_out_data.scl_release;
    assign o_out.sda_release    = r_out_data.sda_release;
    assign o_out.busy_res       = r_out_data.busy_res;
    assign o_out.done_res       = r_out_data.done_res;
    assign o_out.read_data      = r_out_data.read_data;
    assign o_out.ack_write_addr = r_out_data.ack_write_addr;
    assign o_out.ack_register   = r_out_data.ack_register;
    assign o_out.ack_read_addr  = r_out_data.ack_read_addr;

    // The skid register is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while the output register is empty");

    // A word taken while the output is stalled must land in the skid register.
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("word accepted during a stall was not buffered");

    // The tick that completes the stop leaves the block idle with both lines released.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.done_res) |->
            (!r_out_data.busy_res && r_out_data.scl_release && r_out_data.sda_release))
        else $error("done reported while busy or with a line driven low");

endmodule
